/* src/assert_macros.svh */
// Assertion helpers used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with a synchronous active-high reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same, but also checked while reset is high
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/mvpt_pkg.sv */
`default_nettype none
package mvpt_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int COEF_WIDTH_DEF  = 18;
   localparam int CSR_ADDR_WIDTH  = 3;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_ROW_0    = 3'd0,
      CSR_ROW_1    = 3'd1,
      CSR_ROW_2    = 3'd2,
      CSR_DISTANCE = 3'd3,
      CSR_PERSP_EN = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SAT      = 2'd1,
      STATUS_ZERO_DIV = 2'd2
   } status_type;

   // per-transaction flags carried alongside the data
   typedef struct packed {
      logic persp;
      logic zero_div;
      logic sat;
      logic x_neg;
      logic x_zero;
      logic y_neg;
      logic y_zero;
      logic d_neg;
   } flags_type;

endpackage
`default_nettype wire

/* src/mvpt_req_if.sv */
`default_nettype none
interface mvpt_req_if #(
   parameter int COORD_WIDTH = mvpt_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic signed [COORD_WIDTH-1:0] point_z;

   modport source (output valid, output point_x, output point_y, output point_z,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input point_z,
                   output ready);
endinterface
`default_nettype wire

/* src/mvpt_rsp_if.sv */
`default_nettype none
interface mvpt_rsp_if #(
   parameter int COORD_WIDTH = mvpt_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] result_x;
   logic signed [COORD_WIDTH-1:0] result_y;
   logic signed [COORD_WIDTH-1:0] result_z;
   logic [1:0]                    status;

   modport source (output valid, output result_x, output result_y, output result_z,
                   output status, input ready);
   modport sink   (input valid, input result_x, input result_y, input result_z,
                   input status, output ready);
endinterface
`default_nettype wire

/* src/mvpt_dot.sv */
`default_nettype none
module mvpt_dot #(
   parameter int COORD_WIDTH = mvpt_pkg::COORD_WIDTH_DEF,
   parameter int COEF_WIDTH  = mvpt_pkg::COEF_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          in_valid,
   input  wire logic signed [COORD_WIDTH-1:0] point_x,
   input  wire logic signed [COORD_WIDTH-1:0] point_y,
   input  wire logic signed [COORD_WIDTH-1:0] point_z,
   input  wire logic [3*COEF_WIDTH-1:0]       row_0,
   input  wire logic [3*COEF_WIDTH-1:0]       row_1,
   input  wire logic [3*COEF_WIDTH-1:0]       row_2,
   input  wire logic signed [COORD_WIDTH-1:0] distance,
   input  wire logic                          persp_en,
   output logic                               out_valid,
   output mvpt_pkg::flags_type                out_flags,
   output logic signed [COORD_WIDTH-1:0]      out_rx,
   output logic signed [COORD_WIDTH-1:0]      out_ry,
   output logic signed [COORD_WIDTH-1:0]      out_rz,
   output logic [COORD_WIDTH-1:0]             out_abs_x,
   output logic [COORD_WIDTH-1:0]             out_abs_y,
   output logic [COORD_WIDTH:0]               out_abs_den
);
   import mvpt_pkg::*;

   localparam int PW   = COORD_WIDTH + COEF_WIDTH;
   localparam int SW   = PW + 2;
   localparam int FRAC = COEF_WIDTH - 2;
   localparam logic signed [COORD_WIDTH-1:0] MAXV = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] MINV = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   logic [3*COEF_WIDTH-1:0]       rows [3];
   logic signed [COORD_WIDTH-1:0] pts [3];
   logic signed [COEF_WIDTH-1:0]  coef [3][3];

   // stage 1: nine products
   logic signed [PW-1:0] prod_in [3][3];
   logic signed [PW-1:0] prod_ff [3][3];
   logic                 valid1_ff;
   logic                 persp1_ff;

   // stage 2: row sums, floor to coordinate format, clamp
   logic signed [SW-1:0]          sum_sh [3];
   logic signed [COORD_WIDTH-1:0] res_in [3];
   logic [2:0]                    sat_rows;
   logic signed [COORD_WIDTH-1:0] res_ff [3];
   logic                          sat2_ff;
   logic                          valid2_ff;
   logic                          persp2_ff;

   // stage 3: divisor and magnitudes
   logic signed [COORD_WIDTH:0]   den;
   flags_type                     flags_in;

   assign rows[0] = row_0;
   assign rows[1] = row_1;
   assign rows[2] = row_2;
   assign pts[0]  = point_x;
   assign pts[1]  = point_y;
   assign pts[2]  = point_z;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            coef[r][k]    = signed'(rows[r][k*COEF_WIDTH +: COEF_WIDTH]);
            prod_in[r][k] = coef[r][k] * pts[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else if (en) begin
         valid1_ff <= in_valid;
      end
      if (en) begin
         prod_ff   <= prod_in;
         persp1_ff <= persp_en;
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sum_sh[r] = (SW'(prod_ff[r][0]) + SW'(prod_ff[r][1]) + SW'(prod_ff[r][2])) >>> FRAC;
         if (!sum_sh[r][SW-1] && (|sum_sh[r][SW-2:COORD_WIDTH-1])) begin
            res_in[r]   = MAXV;
            sat_rows[r] = 1'b1;
         end else if (sum_sh[r][SW-1] && !(&sum_sh[r][SW-2:COORD_WIDTH-1])) begin
            res_in[r]   = MINV;
            sat_rows[r] = 1'b1;
         end else begin
            res_in[r]   = sum_sh[r][COORD_WIDTH-1:0];
            sat_rows[r] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else if (en) begin
         valid2_ff <= valid1_ff;
      end
      if (en) begin
         res_ff    <= res_in;
         sat2_ff   <= |sat_rows;
         persp2_ff <= persp1_ff;
      end
   end

   always_comb begin
      den               = (COORD_WIDTH+1)'(res_ff[2]) + (COORD_WIDTH+1)'(distance);
      flags_in.persp    = persp2_ff;
      flags_in.zero_div = persp2_ff && (den == '0);
      flags_in.sat      = sat2_ff;
      flags_in.x_neg    = res_ff[0][COORD_WIDTH-1];
      flags_in.x_zero   = (res_ff[0] == '0);
      flags_in.y_neg    = res_ff[1][COORD_WIDTH-1];
      flags_in.y_zero   = (res_ff[1] == '0);
      flags_in.d_neg    = den[COORD_WIDTH];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (en) begin
         out_valid <= valid2_ff;
      end
      if (en) begin
         out_flags   <= flags_in;
         out_rx      <= res_ff[0];
         out_ry      <= res_ff[1];
         out_rz      <= res_ff[2];
         out_abs_x   <= res_ff[0][COORD_WIDTH-1] ? -res_ff[0] : res_ff[0];
         out_abs_y   <= res_ff[1][COORD_WIDTH-1] ? -res_ff[1] : res_ff[1];
         out_abs_den <= den[COORD_WIDTH] ? -den : den;
      end
   end

endmodule
`default_nettype wire

/* src/mvpt_div.sv */
`default_nettype none
module mvpt_div #(
   parameter int COORD_WIDTH = mvpt_pkg::COORD_WIDTH_DEF,
   parameter int QUOT_WIDTH  = COORD_WIDTH + COORD_WIDTH / 2
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          in_valid,
   input  wire mvpt_pkg::flags_type           in_flags,
   input  wire logic signed [COORD_WIDTH-1:0] in_rx,
   input  wire logic signed [COORD_WIDTH-1:0] in_ry,
   input  wire logic signed [COORD_WIDTH-1:0] in_rz,
   input  wire logic [COORD_WIDTH-1:0]        in_abs_x,
   input  wire logic [COORD_WIDTH-1:0]        in_abs_y,
   input  wire logic [COORD_WIDTH:0]          in_abs_den,
   output logic                               out_valid,
   output mvpt_pkg::flags_type                out_flags,
   output logic signed [COORD_WIDTH-1:0]      out_rx,
   output logic signed [COORD_WIDTH-1:0]      out_ry,
   output logic signed [COORD_WIDTH-1:0]      out_rz,
   output logic [QUOT_WIDTH-1:0]              out_q_x,
   output logic [QUOT_WIDTH-1:0]              out_q_y
);
   import mvpt_pkg::*;

   localparam int STEPS = QUOT_WIDTH;
   localparam int FRAC  = QUOT_WIDTH - COORD_WIDTH;

   // one restoring step per stage; lane 0 is x, lane 1 is y
   logic [QUOT_WIDTH-1:0]         src_nq  [STEPS][2];
   logic [COORD_WIDTH:0]          src_rem [STEPS][2];
   logic [COORD_WIDTH:0]          src_den [STEPS];
   logic                          src_valid [STEPS];
   flags_type                     src_flags [STEPS];
   logic signed [COORD_WIDTH-1:0] src_rx [STEPS];
   logic signed [COORD_WIDTH-1:0] src_ry [STEPS];
   logic signed [COORD_WIDTH-1:0] src_rz [STEPS];

   logic [QUOT_WIDTH-1:0]         nq_in  [STEPS][2];
   logic [COORD_WIDTH:0]          rem_in [STEPS][2];
   logic [QUOT_WIDTH-1:0]         nq_ff  [STEPS][2];
   logic [COORD_WIDTH:0]          rem_ff [STEPS][2];
   logic [COORD_WIDTH:0]          den_ff [STEPS];
   logic                          valid_ff [STEPS];
   flags_type                     flags_ff [STEPS];
   logic signed [COORD_WIDTH-1:0] rx_ff [STEPS];
   logic signed [COORD_WIDTH-1:0] ry_ff [STEPS];
   logic signed [COORD_WIDTH-1:0] rz_ff [STEPS];

   for (genvar s = 0; s < STEPS; s++) begin : g_step
      if (s == 0) begin : g_load
         assign src_nq[s][0]  = {in_abs_x, {FRAC{1'b0}}};
         assign src_nq[s][1]  = {in_abs_y, {FRAC{1'b0}}};
         assign src_rem[s][0] = '0;
         assign src_rem[s][1] = '0;
         assign src_den[s]    = in_abs_den;
         assign src_valid[s]  = in_valid;
         assign src_flags[s]  = in_flags;
         assign src_rx[s]     = in_rx;
         assign src_ry[s]     = in_ry;
         assign src_rz[s]     = in_rz;
      end else begin : g_chain
         assign src_nq[s]    = nq_ff[s-1];
         assign src_rem[s]   = rem_ff[s-1];
         assign src_den[s]   = den_ff[s-1];
         assign src_valid[s] = valid_ff[s-1];
         assign src_flags[s] = flags_ff[s-1];
         assign src_rx[s]    = rx_ff[s-1];
         assign src_ry[s]    = ry_ff[s-1];
         assign src_rz[s]    = rz_ff[s-1];
      end

      always_comb begin : trial
         logic [COORD_WIDTH+3:0] shifted;
         logic [COORD_WIDTH+3:0] diff;
         logic                   ge;
         for (int l = 0; l < 2; l++) begin
            shifted     = {2'b00, src_rem[s][l], src_nq[s][l][QUOT_WIDTH-1]};
            diff        = shifted - (COORD_WIDTH+4)'(src_den[s]);
            ge          = !diff[COORD_WIDTH+3];
            rem_in[s][l] = ge ? diff[COORD_WIDTH:0] : shifted[COORD_WIDTH:0];
            nq_in[s][l]  = {src_nq[s][l][QUOT_WIDTH-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= src_valid[s];
         end
         if (en) begin
            nq_ff[s]    <= nq_in[s];
            rem_ff[s]   <= rem_in[s];
            den_ff[s]   <= src_den[s];
            flags_ff[s] <= src_flags[s];
            rx_ff[s]    <= src_rx[s];
            ry_ff[s]    <= src_ry[s];
            rz_ff[s]    <= src_rz[s];
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_flags = flags_ff[STEPS-1];
   assign out_rx    = rx_ff[STEPS-1];
   assign out_ry    = ry_ff[STEPS-1];
   assign out_rz    = rz_ff[STEPS-1];
   assign out_q_x   = nq_ff[STEPS-1][0];
   assign out_q_y   = nq_ff[STEPS-1][1];

endmodule
`default_nettype wire

/* src/mvpt_fin.sv */
`default_nettype none
module mvpt_fin #(
   parameter int COORD_WIDTH = mvpt_pkg::COORD_WIDTH_DEF,
   parameter int QUOT_WIDTH  = COORD_WIDTH + COORD_WIDTH / 2
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          in_valid,
   input  wire mvpt_pkg::flags_type           in_flags,
   input  wire logic signed [COORD_WIDTH-1:0] in_rx,
   input  wire logic signed [COORD_WIDTH-1:0] in_ry,
   input  wire logic signed [COORD_WIDTH-1:0] in_rz,
   input  wire logic [QUOT_WIDTH-1:0]         in_q_x,
   input  wire logic [QUOT_WIDTH-1:0]         in_q_y,
   output logic                               out_valid,
   output logic signed [COORD_WIDTH-1:0]      out_x,
   output logic signed [COORD_WIDTH-1:0]      out_y,
   output logic signed [COORD_WIDTH-1:0]      out_z,
   output logic [1:0]                         out_status
);
   import mvpt_pkg::*;

   localparam logic [COORD_WIDTH-1:0] MAXV = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic [COORD_WIDTH-1:0] MINV = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam logic [QUOT_WIDTH-1:0]  LIM  = QUOT_WIDTH'(1) << (COORD_WIDTH - 1);

   // returns {saturated, value}
   function automatic logic [COORD_WIDTH:0] resolve(
      input logic [QUOT_WIDTH-1:0]  q,
      input logic                   num_neg,
      input logic                   num_zero,
      input flags_type              f,
      input logic [COORD_WIDTH-1:0] plain
   );
      logic                   big;
      logic                   sat;
      logic [COORD_WIDTH-1:0] val;
      big = |q[QUOT_WIDTH-1:COORD_WIDTH-1];
      sat = 1'b0;
      priority if (!f.persp) begin
         val = plain;
      end else if (f.zero_div) begin
         val = num_zero ? '0 : (num_neg ? MINV : MAXV);
      end else if (num_neg ^ f.d_neg) begin
         sat = big && (q != LIM);
         val = sat ? MINV : -q[COORD_WIDTH-1:0];
      end else begin
         sat = big;
         val = sat ? MAXV : q[COORD_WIDTH-1:0];
      end
      return {sat, val};
   endfunction

   logic [COORD_WIDTH:0] res_x;
   logic [COORD_WIDTH:0] res_y;
   status_type           status_in;

   always_comb begin
      res_x = resolve(in_q_x, in_flags.x_neg, in_flags.x_zero, in_flags, in_rx);
      res_y = resolve(in_q_y, in_flags.y_neg, in_flags.y_zero, in_flags, in_ry);
      priority if (in_flags.zero_div) begin
         status_in = STATUS_ZERO_DIV;
      end else if (in_flags.sat || res_x[COORD_WIDTH] || res_y[COORD_WIDTH]) begin
         status_in = STATUS_SAT;
      end else begin
         status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (en) begin
         out_valid <= in_valid;
      end
      if (en) begin
         out_x      <= res_x[COORD_WIDTH-1:0];
         out_y      <= res_y[COORD_WIDTH-1:0];
         out_z      <= in_rz;
         out_status <= status_in;
      end
   end

endmodule
`default_nettype wire

/* src/matrix_vector_perspective_transform_top.sv */
// Channel   Direction  Handshake      Payload
// req_chan  in         valid / ready  point_x, point_y, point_z
// rsp_chan  out        valid / ready  result_x, result_y, result_z, status
// csr_*     in         csr_wen only   csr_addr, csr_wdata
//
// One transaction per cycle while the skid register is empty; most of the pipeline is
// the restoring divider, which computes one quotient bit a stage.
// Reset is synchronous, active high; it clears valid bits and loads the identity matrix.
// Every stage moves on one shared enable, which drops only while the skid register is full.
// A result stalled on rsp_chan parks in the skid register, so nothing is lost or repeated.
`default_nettype none
`include "assert_macros.svh"
module matrix_vector_perspective_transform_top #(
   parameter int COORD_WIDTH = mvpt_pkg::COORD_WIDTH_DEF,
   parameter int COEF_WIDTH  = mvpt_pkg::COEF_WIDTH_DEF
) (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   mvpt_req_if.sink                                          req_chan,
   mvpt_rsp_if.source                                        rsp_chan,
   input  wire logic                                         csr_wen,
   input  wire logic [mvpt_pkg::CSR_ADDR_WIDTH-1:0]          csr_addr,
   input  wire logic [((3*COEF_WIDTH > 64) ? 64 : 3*COEF_WIDTH) > COORD_WIDTH ?
                      ((3*COEF_WIDTH > 64) ? 64 : 3*COEF_WIDTH) - 1 :
                      COORD_WIDTH - 1 : 0]                   csr_wdata
);
   import mvpt_pkg::*;

   localparam int ROW_W      = 3 * COEF_WIDTH;
   // coefficient bits at 64 and above read as zero
   localparam int ROW_STORE  = (ROW_W > 64) ? 64 : ROW_W;
   localparam int QUOT_WIDTH = COORD_WIDTH + COORD_WIDTH / 2;

   // configuration registers
   logic [ROW_STORE-1:0]          row_ff [3];
   logic signed [COORD_WIDTH-1:0] distance_ff;
   logic                          persp_en_ff;

   // pipeline enable: hold every stage while the skid register is full
   logic en;

   logic                          dot_valid;
   flags_type                     dot_flags;
   logic signed [COORD_WIDTH-1:0] dot_rx;
   logic signed [COORD_WIDTH-1:0] dot_ry;
   logic signed [COORD_WIDTH-1:0] dot_rz;
   logic [COORD_WIDTH-1:0]        dot_abs_x;
   logic [COORD_WIDTH-1:0]        dot_abs_y;
   logic [COORD_WIDTH:0]          dot_abs_den;

   logic                          div_valid;
   flags_type                     div_flags;
   logic signed [COORD_WIDTH-1:0] div_rx;
   logic signed [COORD_WIDTH-1:0] div_ry;
   logic signed [COORD_WIDTH-1:0] div_rz;
   logic [QUOT_WIDTH-1:0]         div_q_x;
   logic [QUOT_WIDTH-1:0]         div_q_y;

   logic                          fin_valid;
   logic signed [COORD_WIDTH-1:0] fin_x;
   logic signed [COORD_WIDTH-1:0] fin_y;
   logic signed [COORD_WIDTH-1:0] fin_z;
   logic [1:0]                    fin_status;

   // output register and skid register
   logic                          out_valid_ff;
   logic signed [COORD_WIDTH-1:0] out_x_ff;
   logic signed [COORD_WIDTH-1:0] out_y_ff;
   logic signed [COORD_WIDTH-1:0] out_z_ff;
   logic [1:0]                    out_status_ff;
   logic                          skid_valid_ff;
   logic signed [COORD_WIDTH-1:0] skid_x_ff;
   logic signed [COORD_WIDTH-1:0] skid_y_ff;
   logic signed [COORD_WIDTH-1:0] skid_z_ff;
   logic [1:0]                    skid_status_ff;
   logic                          out_take;

   // configuration writes; an index beyond the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            row_ff[k] <= {{(ROW_STORE-1){1'b0}}, 1'b1} << (k * COEF_WIDTH + COEF_WIDTH - 2);
         end
         distance_ff <= '0;
         persp_en_ff <= 1'b0;
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_addr))
            CSR_ROW_0:    row_ff[0]   <= csr_wdata[ROW_STORE-1:0];
            CSR_ROW_1:    row_ff[1]   <= csr_wdata[ROW_STORE-1:0];
            CSR_ROW_2:    row_ff[2]   <= csr_wdata[ROW_STORE-1:0];
            CSR_DISTANCE: distance_ff <= csr_wdata[COORD_WIDTH-1:0];
            CSR_PERSP_EN: persp_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign en             = !skid_valid_ff;
   assign req_chan.ready = en;

   // stages 1 to 3: products, row sums with clamp, divisor and magnitudes
   mvpt_dot #(
      .COORD_WIDTH (COORD_WIDTH),
      .COEF_WIDTH  (COEF_WIDTH)
   ) u_dot (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_chan.valid),
      .point_x     (req_chan.point_x),
      .point_y     (req_chan.point_y),
      .point_z     (req_chan.point_z),
      .row_0       (ROW_W'(row_ff[0])),
      .row_1       (ROW_W'(row_ff[1])),
      .row_2       (ROW_W'(row_ff[2])),
      .distance    (distance_ff),
      .persp_en    (persp_en_ff),
      .out_valid   (dot_valid),
      .out_flags   (dot_flags),
      .out_rx      (dot_rx),
      .out_ry      (dot_ry),
      .out_rz      (dot_rz),
      .out_abs_x   (dot_abs_x),
      .out_abs_y   (dot_abs_y),
      .out_abs_den (dot_abs_den)
   );

   // one quotient bit per stage for x and y side by side
   mvpt_div #(
      .COORD_WIDTH (COORD_WIDTH),
      .QUOT_WIDTH  (QUOT_WIDTH)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (dot_valid),
      .in_flags   (dot_flags),
      .in_rx      (dot_rx),
      .in_ry      (dot_ry),
      .in_rz      (dot_rz),
      .in_abs_x   (dot_abs_x),
      .in_abs_y   (dot_abs_y),
      .in_abs_den (dot_abs_den),
      .out_valid  (div_valid),
      .out_flags  (div_flags),
      .out_rx     (div_rx),
      .out_ry     (div_ry),
      .out_rz     (div_rz),
      .out_q_x    (div_q_x),
      .out_q_y    (div_q_y)
   );

   // sign, saturation, zero divisor and status
   mvpt_fin #(
      .COORD_WIDTH (COORD_WIDTH),
      .QUOT_WIDTH  (QUOT_WIDTH)
   ) u_fin (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (div_valid),
      .in_flags   (div_flags),
      .in_rx      (div_rx),
      .in_ry      (div_ry),
      .in_rz      (div_rz),
      .in_q_x     (div_q_x),
      .in_q_y     (div_q_y),
      .out_valid  (fin_valid),
      .out_x      (fin_x),
      .out_y      (fin_y),
      .out_z      (fin_z),
      .out_status (fin_status)
   );

   // output register: refill from the skid register first, else from the pipe;
   // park a pipe result in the skid register when the output is stalled
   assign out_take = !out_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (out_take) begin
         out_valid_ff <= fin_valid;
      end else if (fin_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_take) begin
            out_x_ff      <= skid_x_ff;
            out_y_ff      <= skid_y_ff;
            out_z_ff      <= skid_z_ff;
            out_status_ff <= skid_status_ff;
         end
      end else if (out_take) begin
         out_x_ff      <= fin_x;
         out_y_ff      <= fin_y;
         out_z_ff      <= fin_z;
         out_status_ff <= fin_status;
      end else begin
         skid_x_ff      <= fin_x;
         skid_y_ff      <= fin_y;
         skid_z_ff      <= fin_z;
         skid_status_ff <= fin_status;
      end
   end

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.result_x = out_x_ff;
   assign rsp_chan.result_y = out_y_ff;
   assign rsp_chan.result_z = out_z_ff;
   assign rsp_chan.status   = out_status_ff;

   // the skid register is only ever filled behind a held output
   `ASSERT_CLK(a_skid_behind_out, clock, reset, skid_valid_ff |-> out_valid_ff, "skid full with output empty")
   `ASSERT_CLK(a_skid_fill_cause, clock, reset, $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_chan.ready), "skid filled without a stall")
   // a zero-divisor status can only come out with perspective on
   `ASSERT_CLK(a_zero_div_persp, clock, reset, (rsp_chan.valid && rsp_chan.status == STATUS_ZERO_DIV) |-> persp_en_ff, "zero divisor reported with perspective off")

endmodule
`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps
`default_nettype none

// Transform checker: keeps the matrix and perspective settings, and predicts the
// result of every accepted point in arrival order.
class transform_checker;
   typedef struct {
      logic signed [31:0]   x;
      logic signed [31:0]   y;
      logic signed [31:0]   z;
      mvpt_pkg::status_type status;
   } transformed_point_type;

   logic [53:0]          rows [3];
   logic signed [31:0]   distance;
   bit                   persp_on;
   transformed_point_type pending_points [$];
   int                   failures;
   int                   checked;
   int                   zero_div_seen;
   int                   sat_seen;

   function new();
      rows[0]  = 54'd1 << 16;
      rows[1]  = 54'd1 << 34;
      rows[2]  = 54'd1 << 52;
      distance = '0;
      persp_on = 1'b0;
      failures = 0;
      checked  = 0;
      zero_div_seen = 0;
      sat_seen = 0;
   endfunction

   function void set_register(mvpt_pkg::csr_index_type idx, logic [53:0] value);
      case (idx)
         mvpt_pkg::CSR_ROW_0, mvpt_pkg::CSR_ROW_1, mvpt_pkg::CSR_ROW_2: rows[idx] = value;
         mvpt_pkg::CSR_DISTANCE: distance = value[31:0];
         mvpt_pkg::CSR_PERSP_EN: persp_on = value[0];
         default: ;
      endcase
   endfunction

   function logic signed [63:0] clamp32(logic signed [63:0] v, inout bit sat);
      if (v > 64'sd2147483647) begin
         sat = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         sat = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // exact dot product, floored to Q16.16, then clamped
   function logic signed [63:0] dot_row(logic [53:0] row, logic signed [63:0] p [3],
                                        inout bit sat);
      logic signed [63:0] acc;
      logic signed [63:0] c;
      acc = '0;
      for (int k = 0; k < 3; k++) begin
         c   = $signed(row[k*18 +: 18]);
         acc = acc + c * p[k];
      end
      return clamp32(acc >>> 16, sat);
   endfunction

   // (num << 16) / den, truncated toward zero, clamped
   function logic signed [63:0] divide_depth(logic signed [63:0] num, logic signed [63:0] den,
                                             inout bit sat);
      logic [63:0] an;
      logic [63:0] ad;
      logic [63:0] q;
      an = (num < 0) ? -num : num;
      ad = (den < 0) ? -den : den;
      q  = (an << 16) / ad;
      if ((num < 0) != (den < 0)) begin
         if (q > 64'd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
         end
         return -$signed(q);
      end
      if (q > 64'd2147483647) begin
         sat = 1'b1;
         return 64'sd2147483647;
      end
      return $signed(q);
   endfunction

   function void note_point(logic signed [31:0] px, logic signed [31:0] py,
                            logic signed [31:0] pz);
      logic signed [63:0]    p [3];
      logic signed [63:0]    rx, ry, rz, den;
      bit                    sat;
      bit                    zero_div;
      transformed_point_type e;
      sat = 1'b0;
      zero_div = 1'b0;
      p[0] = px;
      p[1] = py;
      p[2] = pz;
      rx = dot_row(rows[0], p, sat);
      ry = dot_row(rows[1], p, sat);
      rz = dot_row(rows[2], p, sat);
      if (persp_on) begin
         den = rz + 64'(distance);
         if (den == 0) begin
            zero_div = 1'b1;
            rx = (rx > 0) ? 64'sd2147483647 : ((rx < 0) ? -64'sd2147483648 : 64'sd0);
            ry = (ry > 0) ? 64'sd2147483647 : ((ry < 0) ? -64'sd2147483648 : 64'sd0);
         end else begin
            rx = divide_depth(rx, den, sat);
            ry = divide_depth(ry, den, sat);
         end
      end
      e.x = rx[31:0];
      e.y = ry[31:0];
      e.z = rz[31:0];
      e.status = zero_div ? mvpt_pkg::STATUS_ZERO_DIV
                          : (sat ? mvpt_pkg::STATUS_SAT : mvpt_pkg::STATUS_OK);
      if (zero_div) zero_div_seen++;
      else if (sat) sat_seen++;
      pending_points.push_back(e);
   endfunction

   function void check_result(logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z, logic [1:0] status);
      transformed_point_type e;
      if (pending_points.size() == 0) begin
         $error("result with no point outstanding: x %0d y %0d z %0d status %0d",
                x, y, z, status);
         failures++;
         return;
      end
      e = pending_points.pop_front();
      checked++;
      if (x !== e.x) begin
         $error("result_x: expected %0d, actual %0d", e.x, x);
         failures++;
      end
      if (y !== e.y) begin
         $error("result_y: expected %0d, actual %0d", e.y, y);
         failures++;
      end
      if (z !== e.z) begin
         $error("result_z: expected %0d, actual %0d", e.z, z);
         failures++;
      end
      if (status !== e.status) begin
         $error("status: expected %0d, actual %0d", e.status, status);
         failures++;
      end
   endfunction
endclass

module testbench;
   import mvpt_pkg::*;

   localparam int LATENCY_WAIT = 70;   // covers the pipeline latency with slack
   localparam int STALL_LIMIT  = 3000; // cycles without a transaction before giving up

   logic        clock;
   logic        reset;
   logic        csr_wen;
   logic [2:0]  csr_addr;
   logic [53:0] csr_wdata;

   mvpt_req_if req_chan ();
   mvpt_rsp_if rsp_chan ();

   matrix_vector_perspective_transform_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_wen  (csr_wen),
      .csr_addr (csr_addr),
      .csr_wdata(csr_wdata)
   );

   transform_checker tracker = new();
   int idle_cycles = 0;
   int sent_points = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Check every result transaction at the rising edge it is taken.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         tracker.check_result(rsp_chan.result_x, rsp_chan.result_y,
                              rsp_chan.result_z, rsp_chan.status);
   end

   // Watchdog: count cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("status: fail");
         $finish;
      end
   end

   // Receiver back-pressure: switch between always-ready, random and long-stall
   // modes every so often, so stalls land on every phase of the pipeline.
   int stall_mode = 0;
   int mode_left  = 0;
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(20, 200);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         0:       rsp_chan.ready <= 1'b1;
         1:       rsp_chan.ready <= ($urandom_range(0, 1) == 1);
         2:       rsp_chan.ready <= ($urandom_range(0, 7) == 0);
         default: rsp_chan.ready <= (($urandom_range(0, 3)) != 0);
      endcase
   end

   // Write one register; the block must be idle.
   task automatic write_register(csr_index_type idx, logic [53:0] value);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen   <= 1'b0;
      tracker.set_register(idx, value);
   endtask

   // Hold valid low for the gap, then offer the point until it is taken.
   task automatic send_point(int gap, logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z);
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid   <= 1'b1;
      req_chan.point_x <= x;
      req_chan.point_y <= y;
      req_chan.point_z <= z;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      tracker.note_point(x, y, z);
      sent_points++;
   endtask

   // Drop valid and wait for the pipeline to empty before touching registers.
   task automatic drain_pipeline();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (tracker.pending_points.size() != 0) @(posedge clock);
      repeat (LATENCY_WAIT) @(posedge clock);
   endtask

   function automatic logic [17:0] pick_coef();
      case ($urandom_range(0, 5))
         0:       return 18'h1FFFF;                    // just under +2.0
         1:       return 18'h20000;                    // -2.0
         2:       return 18'($urandom);
         3:       return 18'h0;
         default: return 18'($signed($urandom_range(0, 131072)) - 65536);  // within +-1.0
      endcase
   endfunction

   function automatic logic [53:0] pick_row();
      return {pick_coef(), pick_coef(), pick_coef()};
   endfunction

   function automatic logic signed [31:0] pick_coord();
      case ($urandom_range(0, 4))
         0:       return $urandom;
         1:       return $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh007FFFFF;
         default: return $signed($urandom_range(0, 32'h03FFFFFF)) - 32'sh01FFFFFF;
      endcase
   endfunction

   logic signed [31:0] directed_values [6] = '{32'sh7FFFFFFF, 32'sh80000000, 32'sd0,
                                               -32'sd1, 32'sh00010000, 32'sd1};

   initial begin
      int gap;
      int burst_left;
      logic signed [31:0] px, py, pz;

      reset            = 1'b1;
      csr_wen          = 1'b0;
      csr_addr         = '0;
      csr_wdata        = '0;
      req_chan.valid   = 1'b0;
      req_chan.point_x = '0;
      req_chan.point_y = '0;
      req_chan.point_z = '0;
      rsp_chan.ready   = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: extreme coordinates through the reset (identity) matrix.
      for (int i = 0; i < 6; i++)
         send_point(0, directed_values[i], directed_values[5 - i], directed_values[(i + 2) % 6]);

      // Directed: full-scale coefficients saturate the row sums of extreme points.
      drain_pipeline();
      write_register(CSR_ROW_0, {18'h1FFFF, 18'h1FFFF, 18'h1FFFF});
      write_register(CSR_ROW_1, {18'h20000, 18'h20000, 18'h20000});
      send_point(0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
      send_point(0, 32'sh80000000, 32'sh80000000, 32'sh80000000);
      send_point(1, 32'sd3, -32'sd5, 32'sd7);

      // Directed: perspective on, zero divisor for positive, negative and zero x / y,
      // then a tiny divisor that overflows the quotient, a plain divide, and a negative divisor.
      drain_pipeline();
      write_register(CSR_ROW_0, 54'd1 << 16);
      write_register(CSR_ROW_1, 54'd1 << 34);
      write_register(CSR_DISTANCE, 54'(32'sh00010000));
      write_register(CSR_PERSP_EN, 54'd1);
      send_point(0, 32'sd100, -32'sd100, -32'sh00010000);
      send_point(0, -32'sd7, 32'sd0, -32'sh00010000);
      send_point(0, 32'sd0, 32'sd9, -32'sh00010000);
      send_point(0, 32'sh7FFFFFFF, 32'sh80000000, -32'sh0000FFFF);
      send_point(0, 32'sh00030000, -32'sh00050000, 32'sh00010000);
      send_point(0, 32'sh80000000, 32'sh80000000, -32'sh00020000);

      // Random phases, each with its own settings; extremes of distance included.
      for (int ph = 0; ph < 9; ph++) begin
         drain_pipeline();
         write_register(CSR_ROW_0, pick_row());
         write_register(CSR_ROW_1, pick_row());
         // row 2 as a pure z pass-through in some phases, so zero divisors happen
         write_register(CSR_ROW_2, (ph % 3 == 0) ? (54'd1 << 52) : pick_row());
         case (ph)
            1:       write_register(CSR_DISTANCE, 54'(32'sh7FFFFFFF));
            2:       write_register(CSR_DISTANCE, 54'(32'sh80000000));
            default: write_register(CSR_DISTANCE, 54'(pick_coord()));
         endcase
         write_register(CSR_PERSP_EN, 54'(ph % 4 != 3));
         burst_left = 0;
         for (int n = 0; n < 200; n++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               gap = 0;
            end
            burst_left--;
            px = pick_coord();
            py = pick_coord();
            pz = pick_coord();
            if (tracker.persp_on && $urandom_range(0, 15) == 0)
               pz = -tracker.distance;   // aim at a zero divisor
            send_point(gap, px, py, pz);
         end
      end

      drain_pipeline();
      $display("covered %0d points over 12 register settings: %0d zero-divisor, %0d saturated",
               sent_points, tracker.zero_div_seen, tracker.sat_seen);
      $display("%0d results checked", tracker.checked);
      if (tracker.failures == 0 && tracker.pending_points.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

`default_nettype wire
